/* rtl/pgn_pkg.sv */
// ============================================================================
// pgn_pkg: shared types and constants for the game text tokenizer
// Token classes, parse states, step actions, event codes and the step table.
// ============================================================================
package pgn_pkg;

  typedef enum logic [3:0] {
    ST_HDR = 4'd0, ST_TAG = 4'd1, ST_FEN = 4'd2, ST_CMT = 4'd3, ST_VAR = 4'd4,
    ST_NAG = 4'd5, ST_NMOVE = 4'd6, ST_MNUM = 4'd7, ST_NSAN = 4'd8,
    ST_SAN = 4'd9, ST_RES = 4'd10
  } pstate_t;

  typedef enum logic [4:0] {
    K_OTH, K_SP, K_RS, K_MI, K_DT, K_QT, K_DL, K_LK, K_RK, K_LC, K_RC,
    K_LP, K_RP, K_EV, K_ZR, K_DG, K_HD
  } tok_t;

  typedef enum logic [4:0] {
    A_ERR, A_NOP, A_TAG, A_CMT, A_FCH, A_FEND, A_VAR, A_NAG, A_POP, A_NUM,
    A_SAN, A_CAST, A_MST, A_MCH, A_MEND, A_RES, A_GEND, A_TCMT, A_MISS
  } act_t;

  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_MCHAR = 3'd1;
  localparam logic [2:0] EV_MEND  = 3'd2;
  localparam logic [2:0] EV_FCHAR = 3'd3;
  localparam logic [2:0] EV_FEND  = 3'd4;
  localparam logic [2:0] EV_GEND  = 3'd5;
  localparam logic [2:0] EV_SYNTX = 3'd6;
  localparam logic [2:0] EV_STACK = 3'd7;

  localparam logic [39:0] MOVES_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] GAMES_MAX = 32'hFFFF_FFFF;
  localparam logic [23:0] FEN_BLACK = 24'h206220;
  localparam logic [39:0] FEN_AHEAD = 40'h22_204E_4546;     // 'F','E','N',' ','"'
  localparam logic [47:0] EVENT_AHEAD = 48'h20_746E_6576_45; // "Event "
  localparam logic [7:0]  CH_NL = 8'h0A;
  localparam logic [7:0]  CH_ZERO = 8'h30;

  function automatic tok_t classify(input logic [7:0] b);
    tok_t k;
    k = K_OTH;
    if (b >= 8'h31 && b <= 8'h39) k = K_DG;
    else if (b >= 8'h61 && b <= 8'h68) k = K_HD;
    else begin
      case (b)
        8'h0A, 8'h0D, 8'h20, 8'h09, 8'h21, 8'h3F, 8'h2B, 8'h23: k = K_SP;
        8'h2F, 8'h2A: k = K_RS;
        8'h2D: k = K_MI;
        8'h2E: k = K_DT;
        8'h22: k = K_QT;
        8'h24: k = K_DL;
        8'h5B: k = K_LK;
        8'h5D: k = K_RK;
        8'h7B: k = K_LC;
        8'h7D: k = K_RC;
        8'h28: k = K_LP;
        8'h29: k = K_RP;
        8'h45: k = K_EV;
        8'h30: k = K_ZR;
        8'h4E, 8'h42, 8'h52, 8'h51, 8'h4B, 8'h4F, 8'h6F: k = K_HD;
        default: k = K_OTH;
      endcase
    end
    return k;
  endfunction

  function automatic act_t step_action(input logic [3:0] st, input tok_t k);
    act_t a;
    a = A_NOP;
    case (st)
      ST_TAG: a = (k == K_RK) ? A_POP : A_NOP;
      ST_FEN: a = (k == K_QT) ? A_FEND : A_FCH;
      ST_CMT: a = (k == K_LK) ? A_TCMT : (k == K_RC) ? A_POP : A_NOP;
      ST_VAR: begin
        case (k)
          K_LC: a = A_CMT;
          K_LP: a = A_VAR;
          K_RP: a = A_POP;
          default: a = A_NOP;
        endcase
      end
      ST_NAG: a = (k == K_ZR || k == K_DG) ? A_NOP : A_POP;
      ST_NMOVE: begin
        case (k)
          K_RS, K_ZR: a = A_RES;
          K_MI, K_DT, K_HD: a = A_ERR;
          K_DL: a = A_NAG;
          K_LK: a = A_MISS;
          K_LC: a = A_CMT;
          K_LP: a = A_VAR;
          K_DG: a = A_NUM;
          default: a = A_NOP;
        endcase
      end
      ST_MNUM: begin
        case (k)
          K_SP, K_DT: a = A_SAN;
          K_RS, K_MI: a = A_RES;
          K_ZR, K_DG: a = A_NOP;
          default: a = A_ERR;
        endcase
      end
      ST_NSAN: begin
        case (k)
          K_RS: a = A_RES;
          K_MI, K_HD: a = A_MST;
          K_DL: a = A_NAG;
          K_LK: a = A_MISS;
          K_LC: a = A_CMT;
          K_LP: a = A_VAR;
          K_ZR: a = A_CAST;
          K_DG: a = A_NUM;
          default: a = A_NOP;
        endcase
      end
      ST_SAN: a = (k == K_SP) ? A_MEND : (k == K_LC) ? A_CMT : A_MCH;
      ST_RES: a = (k == K_SP) ? A_GEND : A_NOP;
      default: begin
        case (k)
          K_RS, K_ZR: a = A_RES;
          K_LK: a = A_TAG;
          K_LC: a = A_CMT;
          K_DG: a = A_NUM;
          default: a = A_NOP;
        endcase
      end
    endcase
    return a;
  endfunction

endpackage

/* rtl/pgn_out_buf.sv */
// ============================================================================
// pgn_out_buf: two-entry result skid buffer
// Holds up to two result transactions and presents them in order.
// ============================================================================
module pgn_out_buf import pgn_pkg::*; #(
  parameter int W = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         space_two,
  output logic         rd_valid,
  output logic [W-1:0] rd_data,
  input  logic         rd_ready
);

  logic [W-1:0] slot [2];
  logic         rd_ptr, wr_ptr;
  logic [1:0]   count;
  logic         pop;

  assign pop = rd_valid && rd_ready;
  assign rd_valid = (count != 2'd0);
  assign rd_data = slot[rd_ptr];
  assign space_two = (count == 2'd0) || ((count == 2'd1) && pop) || ((count == 2'd2) && 1'b0);

  always_ff @(posedge clk) begin
    if (wr_en) slot[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr_en} - {1'b0, pop};
    end
  end

endmodule

/* rtl/pgn_game_stream_tokenizer_unit.sv */
// ============================================================================
// pgn_game_stream_tokenizer_unit: chess game text tokenizer
// Classifies each byte, steps the parse table with a state stack and emits
// one event per byte, plus a game end at end of stream when a game is open.
// ============================================================================
// Latency: an accepted byte's first result is visible the cycle after the
// accept, after one pass of the step logic into the output register.
// Throughput: one byte per cycle while the output keeps up; a game close at
// end of stream yields two results and holds input off for the second.
// Reset: rst is synchronous and active high and returns the parser to the
// header state with an empty stack and zero totals.
module pgn_game_stream_tokenizer_unit import pgn_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int OFFSET_BITS = 40
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // text_byte[7:0], lookahead_bytes[55:8]
  input  logic [55:0]  s_tdata,
  // end_of_stream
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // event_code[2:0], event_byte[10:3], game_offset[50:11], games_total[82:51],
  // moves_total[122:83], black_to_move[123], zero fill to 128 bits
  output logic [127:0] m_tdata,
  // run_last
  output logic         m_tlast
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Parser state.
  logic [3:0]             parse_state;
  logic [3:0]             state_stack [STACK_DEPTH];
  logic [SPW-1:0]         stack_pointer;
  logic                   side_black, fen_black_seen, moves_pending;
  logic [2:0]             skip_remaining;
  logic [23:0]            fen_tail;
  logic [OFFSET_BITS-1:0] byte_position, game_origin;
  logic [31:0]            games_count;
  logic [39:0]            moves_count;

  logic [7:0]  b;
  logic [47:0] la;
  logic        eos, acc;
  assign b = s_tdata[7:0];
  assign la = s_tdata[55:8];
  assign eos = s_tuser;

  // Second word written in the cycle after the first.
  logic         pend2;
  logic [127:0] pend_word;
  logic         wr_en;
  logic [127:0] wr_data;

  // While the close word waits, the input is held off, so no byte races it.
  logic space_two;
  assign s_tready = space_two && !pend2;
  assign acc = s_tvalid && s_tready;

  // Next-state values from one step.
  logic [3:0]             ps_n;
  logic [SPW-1:0]         sp_n;
  logic                   sb_n, fbs_n, mp_n;
  logic [2:0]             skip_n;
  logic [23:0]            ft_n;
  logic [OFFSET_BITS-1:0] gs_n;
  logic [31:0]            gc_n;
  logic [39:0]            mc_n;
  logic                   push_en;
  logic [3:0]             push_val;
  logic [2:0]             ev;
  logic [7:0]             eb;
  logic [OFFSET_BITS-1:0] go;
  logic                   full, empty, close;
  logic [3:0]             top;
  act_t                   act;

  assign full = (stack_pointer >= SPW'(STACK_DEPTH));
  assign empty = (stack_pointer == '0);
  assign top = state_stack[SIW'(stack_pointer - SPW'(1))];
  assign act = step_action(parse_state, classify(b));

  always_comb begin
    ps_n = parse_state; sp_n = stack_pointer; sb_n = side_black;
    fbs_n = fen_black_seen; mp_n = moves_pending; skip_n = skip_remaining;
    ft_n = fen_tail; gs_n = game_origin; gc_n = games_count; mc_n = moves_count;
    push_en = 1'b0; push_val = parse_state;
    ev = EV_NONE; eb = 8'd0; go = '0;
    if (skip_remaining != 3'd0) begin
      skip_n = skip_remaining - 3'd1;
    end else begin
      case (act)
        A_ERR: ev = EV_SYNTX;
        A_TAG, A_CMT, A_VAR, A_NAG: begin
          if (full) ev = EV_STACK;
          else begin
            push_en = 1'b1;
            sp_n = stack_pointer + SPW'(1);
            if (act == A_CMT) ps_n = ST_CMT;
            else if (act == A_VAR) ps_n = ST_VAR;
            else if (act == A_NAG) ps_n = ST_NAG;
            else if (la[39:0] == FEN_AHEAD) begin
              ps_n = ST_FEN; skip_n = 3'd5;
            end else ps_n = ST_TAG;
          end
        end
        A_FCH: begin
          ev = EV_FCHAR; eb = b;
          ft_n = {fen_tail[15:0], b};
          if ({fen_tail[15:0], b} == FEN_BLACK) fbs_n = 1'b1;
        end
        A_FEND: begin
          ev = EV_FEND; ft_n = '0;
          if (fen_black_seen) sb_n = 1'b1;
          ps_n = ST_TAG;
        end
        A_POP: begin
          if (empty) ev = EV_STACK;
          else begin
            sp_n = stack_pointer - SPW'(1);
            ps_n = top;
          end
        end
        A_NUM: ps_n = ST_MNUM;
        A_SAN: ps_n = ST_NSAN;
        A_RES: ps_n = ST_RES;
        A_CAST: begin
          if (la[15:8] != CH_ZERO) ps_n = ST_RES;
          else begin
            ev = EV_MCHAR; eb = b; mp_n = 1'b1; ps_n = ST_SAN;
          end
        end
        A_MST: begin
          ev = EV_MCHAR; eb = b; mp_n = 1'b1; ps_n = ST_SAN;
        end
        A_MCH: begin
          ev = EV_MCHAR; eb = b; mp_n = 1'b1;
        end
        A_MEND: begin
          ev = EV_MEND;
          if (moves_count < MOVES_MAX) mc_n = moves_count + 40'd1;
          ps_n = side_black ? ST_NMOVE : ST_NSAN;
          sb_n = ~side_black;
        end
        A_GEND: begin
          if (b != CH_NL) ps_n = ST_RES;
          else begin
            ev = EV_GEND; go = game_origin;
            if (games_count < GAMES_MAX) gc_n = games_count + 32'd1;
            gs_n = byte_position + OFFSET_BITS'(1);
            sb_n = 1'b0; mp_n = 1'b0; ft_n = '0; fbs_n = 1'b0; ps_n = ST_HDR;
          end
        end
        A_TCMT, A_MISS: begin
          if (act == A_MISS || la == EVENT_AHEAD) begin
            ev = EV_GEND; go = game_origin;
            if (games_count < GAMES_MAX) gc_n = games_count + 32'd1;
            gs_n = byte_position;
            sb_n = 1'b0; mp_n = 1'b0; ft_n = '0; fbs_n = 1'b0;
            push_val = ST_HDR;
            if (!full) begin
              push_en = 1'b1; sp_n = stack_pointer + SPW'(1);
            end
            ps_n = ST_TAG;
          end
        end
        default: ;
      endcase
    end
    close = eos && (ps_n != ST_HDR) && mp_n;
  end

  // Result words: the byte's own event, and the end-of-stream game close.
  logic [127:0] word0, word1;
  logic [31:0]  gc_close;
  assign gc_close = (gc_n < GAMES_MAX) ? gc_n + 32'd1 : gc_n;
  assign word0 = {3'd0, sb_n, mc_n, gc_n, 40'(go), eb, ev, ~close};
  assign word1 = {3'd0, 1'b0, mc_n, gc_close, 40'(gs_n), 8'd0, EV_GEND, 1'b1};

  assign wr_en = acc || pend2;
  assign wr_data = pend2 ? pend_word : word0;

  logic [127:0] rd_word;
  pgn_out_buf #(.W(128)) u_obuf (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_data(wr_data),
    .space_two(space_two), .rd_valid(m_tvalid), .rd_data(rd_word),
    .rd_ready(m_tready)
  );
  assign m_tlast = rd_word[0];
  assign m_tdata = {1'b0, rd_word[127:1]};

  always_ff @(posedge clk) begin
    if (acc && push_en) state_stack[SIW'(stack_pointer)] <= push_val;
    pend_word <= word1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= ST_HDR; stack_pointer <= '0; side_black <= 1'b0;
      fen_black_seen <= 1'b0; moves_pending <= 1'b0; skip_remaining <= 3'd0;
      fen_tail <= '0; byte_position <= '0; game_origin <= '0;
      games_count <= '0; moves_count <= '0; pend2 <= 1'b0;
    end else begin
      pend2 <= acc && close;
      if (acc) begin
        games_count <= close ? gc_close : gc_n;
        moves_count <= mc_n;
        if (eos) begin
          parse_state <= ST_HDR; stack_pointer <= '0; side_black <= 1'b0;
          fen_black_seen <= 1'b0; moves_pending <= 1'b0; skip_remaining <= 3'd0;
          fen_tail <= '0; byte_position <= '0; game_origin <= '0;
        end else begin
          parse_state <= ps_n; stack_pointer <= sp_n; side_black <= sb_n;
          fen_black_seen <= fbs_n; moves_pending <= mp_n; skip_remaining <= skip_n;
          fen_tail <= ft_n; byte_position <= byte_position + OFFSET_BITS'(1);
          game_origin <= gs_n;
        end
      end
    end
  end

  // The stack pointer never passes the stack depth.
  assert property (@(posedge clk) disable iff (rst)
    stack_pointer <= SPW'(STACK_DEPTH)) else $error("stack pointer overrun");
  // A game close at end of stream is followed by its second result write.
  assert property (@(posedge clk) disable iff (rst)
    (acc && close) |=> pend2) else $error("missing close result");
  // No byte is taken while the close result is pending.
  assert property (@(posedge clk) disable iff (rst)
    pend2 |-> !acc) else $error("byte accepted during close");

endmodule
